>>> hw/rtl/tss_pkg.sv
`timescale 1ns / 1ps

package tss_pkg;

  localparam int unsigned MethodCount  = 10;
  localparam int unsigned MethodMaxLen = 8;
  localparam int unsigned PosWidth     = 4;

  localparam logic [7:0] ByteTlsRecord  = 8'h16;
  localparam logic [7:0] ByteTlsMajor   = 8'h03;
  localparam logic [7:0] ByteTlsMinorHi = 8'h04;
  localparam logic [7:0] ByteObfsLo     = 8'ha0;
  localparam logic [7:0] ByteObfsHi     = 8'haf;
  localparam logic [7:0] ByteIdDigit    = 8'h30;
  localparam logic [7:0] ByteSpace      = 8'h20;
  localparam logic [7:0] ByteUpperLo    = 8'h41;
  localparam logic [7:0] ByteUpperHi    = 8'h5a;

  localparam logic [PosWidth-1:0] PosMax = {PosWidth{1'b1}};

  typedef enum logic [2:0] {
    VerdictNeed    = 3'd0,
    VerdictIdLine  = 3'd1,
    VerdictTls     = 3'd2,
    VerdictObfs    = 3'd3,
    VerdictHttp    = 3'd4,
    VerdictUnknown = 3'd5
  } verdict_e;

  typedef enum logic [1:0] {
    BranchNone   = 2'd0,
    BranchIdLine = 2'd1,
    BranchTls    = 2'd2,
    BranchHttp   = 2'd3
  } branch_e;

  typedef logic [0:MethodCount-1][0:MethodMaxLen-1][7:0] method_text_t;
  typedef logic [0:MethodCount-1][PosWidth-1:0]           method_len_t;

  localparam method_text_t MethodText = '{
    '{"G", "E", "T", " ", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"H", "E", "A", "D", " ", 8'h00, 8'h00, 8'h00},
    '{"P", "O", "S", "T", " ", 8'h00, 8'h00, 8'h00},
    '{"P", "U", "T", " ", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"D", "E", "L", "E", "T", "E", " ", 8'h00},
    '{"O", "P", "T", "I", "O", "N", "S", " "},
    '{"P", "A", "T", "C", "H", " ", 8'h00, 8'h00},
    '{"C", "O", "N", "N", "E", "C", "T", " "},
    '{"T", "R", "A", "C", "E", " ", 8'h00, 8'h00},
    '{"P", "R", "I", " ", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam method_len_t MethodLen = '{
    4'd4, 4'd5, 4'd5, 4'd4, 4'd7, 4'd8, 4'd6, 4'd8, 4'd6, 4'd4
  };

  typedef struct packed {
    verdict_e                held;
    logic [PosWidth-1:0]     pos;
    branch_e                 branch;
    logic [MethodCount-1:0]  alive;
    logic                    tls_ok;
  } flow_state_t;

  localparam flow_state_t FlowClear = '{
    held:   VerdictNeed,
    pos:    '0,
    branch: BranchNone,
    alive:  {MethodCount{1'b1}},
    tls_ok: 1'b0
  };

endpackage

>>> hw/rtl/tss_stream_if.sv
`timescale 1ns / 1ps

interface tss_in_if;
  logic       valid;
  logic       ready;
  logic       start_of_flow;
  logic [7:0] data_byte;

  modport source (output valid, output start_of_flow, output data_byte, input ready);
  modport sink   (input valid, input start_of_flow, input data_byte, output ready);
endinterface

interface tss_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] verdict;
  logic       decided;

  modport source (output valid, output verdict, output decided, input ready);
  modport sink   (input valid, input verdict, input decided, output ready);
endinterface

>>> hw/rtl/tcp_stream_protocol_sniffer.sv
`timescale 1ns / 1ps
// A byte enters the input register, then its verdict and flow state register together.
// Throughput: one byte per cycle unless the output stalls; the classifier is combinational.
// A result held at the output does not stop a byte entering an empty input register.
// Reset (rst_ni low, asynchronous) empties both registers and returns the flow state
// to a fresh flow: no verdict, position zero, all methods live.

module tcp_stream_protocol_sniffer import tss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tss_in_if.sink    in_i,
  tss_out_if.source out_o
);

  logic        in_valid_q;
  logic        in_sof_q;
  logic [7:0]  in_byte_q;
  logic        res_valid_q;
  verdict_e    res_verdict_q;
  flow_state_t state_q;
  flow_state_t state_d;
  logic        res_free;
  logic        advance;

  assign res_free   = !res_valid_q || out_o.ready;
  assign advance    = in_valid_q && res_free;
  assign in_i.ready = !in_valid_q || advance;

  tss_classify u_classify (
    .state_i         (state_q),
    .start_of_flow_i (in_sof_q),
    .data_byte_i     (in_byte_q),
    .state_o         (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_sof_q  <= in_i.start_of_flow;
      in_byte_q <= in_i.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      state_q     <= FlowClear;
    end else if (advance) begin
      res_valid_q <= 1'b1;
      state_q     <= state_d;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_verdict_q <= state_d.held;
    end
  end

  assign out_o.valid   = res_valid_q;
  assign out_o.verdict = res_verdict_q;
  assign out_o.decided = (res_verdict_q != VerdictNeed);

endmodule

>>> hw/rtl/tss_classify.sv
`timescale 1ns / 1ps

module tss_classify import tss_pkg::*; (
  input  flow_state_t state_i,
  input  logic        start_of_flow_i,
  input  logic [7:0]  data_byte_i,
  output flow_state_t state_o
);

  flow_state_t            eff;
  logic [MethodCount-1:0] alive_hit;
  logic                   full_hit;
  verdict_e               http_verdict;
  verdict_e               verdict;
  branch_e                branch_n;
  logic [MethodCount-1:0] alive_n;
  logic                   tls_n;

  assign eff = start_of_flow_i ? FlowClear : state_i;

  always_comb begin
    full_hit = 1'b0;
    for (int i = 0; i < MethodCount; i++) begin
      alive_hit[i] = eff.alive[i] && (eff.pos < MethodLen[i]) &&
                     (MethodText[i][eff.pos[2:0]] == data_byte_i);
      if (alive_hit[i] && (eff.pos == MethodLen[i] - 4'd1)) begin
        full_hit = 1'b1;
      end
    end
  end

  always_comb begin
    if (full_hit) begin
      http_verdict = VerdictHttp;
    end else if (|alive_hit) begin
      http_verdict = VerdictNeed;
    end else begin
      http_verdict = VerdictUnknown;
    end
  end

  always_comb begin
    verdict  = VerdictUnknown;
    branch_n = eff.branch;
    alive_n  = eff.alive;
    tls_n    = eff.tls_ok;
    priority if (eff.pos == '0) begin
      priority if (data_byte_i == ByteIdDigit) begin
        branch_n = BranchIdLine;
        verdict  = VerdictNeed;
      end else if (data_byte_i == ByteTlsRecord) begin
        branch_n = BranchTls;
        verdict  = VerdictNeed;
      end else if (data_byte_i >= ByteObfsLo && data_byte_i <= ByteObfsHi) begin
        verdict = VerdictObfs;
      end else if (data_byte_i >= ByteUpperLo && data_byte_i <= ByteUpperHi) begin
        branch_n = BranchHttp;
        alive_n  = alive_hit;
        verdict  = http_verdict;
      end else begin
        verdict = VerdictUnknown;
      end
    end else if (eff.branch == BranchIdLine && eff.pos == 4'd1) begin
      verdict = (data_byte_i == ByteSpace) ? VerdictIdLine : VerdictUnknown;
    end else if (eff.branch == BranchTls && eff.pos == 4'd1) begin
      tls_n   = (data_byte_i == ByteTlsMajor);
      verdict = VerdictNeed;
    end else if (eff.branch == BranchTls && eff.pos == 4'd2) begin
      verdict = (eff.tls_ok && data_byte_i <= ByteTlsMinorHi) ? VerdictTls : VerdictUnknown;
    end else if (eff.branch == BranchHttp && eff.pos < PosWidth'(MethodMaxLen)) begin
      alive_n = alive_hit;
      verdict = http_verdict;
    end else begin
      verdict = VerdictUnknown;
    end
  end

  always_comb begin
    state_o = eff;
    if (eff.held == VerdictNeed) begin
      state_o.held   = verdict;
      state_o.branch = branch_n;
      state_o.alive  = alive_n;
      state_o.tls_ok = tls_n;
    end
    if (eff.pos != PosMax) begin
      state_o.pos = eff.pos + 4'd1;
    end
  end

endmodule
